// File: hdl/ldcf_pkg.sv
// shared types, constants and the microcode table of the led digit chain framer
// no dependencies
package ldcf_pkg;

    // sizing of the digit store
    localparam int CHAINS            = 2;
    localparam int DEVICES_PER_CHAIN = 8;
    localparam int ROWS              = 8;
    localparam int CHAIN_W           = 1;
    localparam int DEV_W             = 3;
    localparam int ROW_W             = 3;
    localparam int ADDR_W            = CHAIN_W + DEV_W + ROW_W;
    localparam int STORE_DEPTH       = 2 ** ADDR_W;
    localparam int PC_W              = 4;

    localparam logic [3:0] DEV_MAX   = 4'(DEVICES_PER_CHAIN);
    localparam logic [3:0] ROW_COUNT = 4'(ROWS);
    localparam logic [1:0] CHAIN_MAX = 2'(CHAINS);
    localparam logic [3:0] NOOP_REG  = 4'h0;

    // command modes
    localparam logic [2:0] MODE_SET_DIGIT = 3'd0;
    localparam logic [2:0] MODE_READ_DIGIT = 3'd1;
    localparam logic [2:0] MODE_REG_ONE    = 3'd2;
    localparam logic [2:0] MODE_REG_ALL    = 3'd3;
    localparam logic [2:0] MODE_ONE_ROW    = 3'd4;
    localparam logic [2:0] MODE_ALL_ROWS   = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_CHAIN  = 2'd1;
    localparam logic [1:0] ST_BAD_DEVICE = 2'd2;
    localparam logic [1:0] ST_BAD_DIGIT  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_CHAINS_IN_USE = 2'd0;
    localparam logic [1:0] CFG_CHAIN_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_DEVICES_A     = 2'd2;
    localparam logic [1:0] CFG_DEVICES_B     = 2'd3;

    // jump conditions
    typedef enum logic [3:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_BAD,
        COND_MODE_SET,
        COND_MODE_READ,
        COND_NDEV_ZERO,
        COND_MODE_REG,
        COND_DEV_NZ,
        COND_ROW_LAST
    } t_cond;

    // result kinds
    typedef enum logic [2:0] {
        EM_NONE,
        EM_PLAIN,
        EM_READ,
        EM_REG,
        EM_ROW
    } t_emit;

    // store address source
    typedef enum logic {
        ADDR_CMD,
        ADDR_CNT
    } t_addr_sel;

    // datapath controls of one step
    typedef struct packed {
        logic      ld_cmd;
        logic      wr_store;
        logic      rd_store;
        t_addr_sel addr_sel;
        t_emit     emit;
        logic      dev_dec;
        logic      dev_init;
        logic      row_inc;
    } t_ctl;

    typedef struct packed {
        t_cond            cond;
        logic [PC_W-1:0]  target;
        t_ctl             ctl;
    } t_uword;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic bad;
        logic mode_set;
        logic mode_read;
        logic mode_reg;
        logic ndev_zero;
        logic dev_zero;
        logic row_last;
        logic out_free;
    } t_flags;

    // step addresses
    localparam logic [PC_W-1:0] PC_FETCH    = 4'd0;
    localparam logic [PC_W-1:0] PC_ROW_RD   = 4'd6;
    localparam logic [PC_W-1:0] PC_REG_EMIT = 4'd10;
    localparam logic [PC_W-1:0] PC_SET      = 4'd12;
    localparam logic [PC_W-1:0] PC_READ_RD  = 4'd13;
    localparam logic [PC_W-1:0] PC_PLAIN    = 4'd15;

    // microcode program
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        unique case (pc)
            4'd0: begin
                w.ctl.ld_cmd = 1'b1;
            end
            4'd1: begin
                w.cond   = COND_BAD;
                w.target = PC_PLAIN;
            end
            4'd2: begin
                w.cond   = COND_MODE_SET;
                w.target = PC_SET;
            end
            4'd3: begin
                w.cond   = COND_MODE_READ;
                w.target = PC_READ_RD;
            end
            4'd4: begin
                w.cond   = COND_NDEV_ZERO;
                w.target = PC_PLAIN;
            end
            4'd5: begin
                w.cond   = COND_MODE_REG;
                w.target = PC_REG_EMIT;
            end
            4'd6: begin
                w.ctl.rd_store = 1'b1;
                w.ctl.addr_sel = ADDR_CNT;
            end
            4'd7: begin
                w.ctl.emit    = EM_ROW;
                w.ctl.dev_dec = 1'b1;
                w.cond        = COND_DEV_NZ;
                w.target      = PC_ROW_RD;
            end
            4'd8: begin
                w.ctl.row_inc  = 1'b1;
                w.ctl.dev_init = 1'b1;
                w.cond         = COND_ROW_LAST;
                w.target       = PC_FETCH;
            end
            4'd9: begin
                w.cond   = COND_ALWAYS;
                w.target = PC_ROW_RD;
            end
            4'd10: begin
                w.ctl.emit    = EM_REG;
                w.ctl.dev_dec = 1'b1;
                w.cond        = COND_DEV_NZ;
                w.target      = PC_REG_EMIT;
            end
            4'd11: begin
                w.cond   = COND_ALWAYS;
                w.target = PC_FETCH;
            end
            4'd12: begin
                w.ctl.wr_store = 1'b1;
                w.ctl.emit     = EM_PLAIN;
                w.cond         = COND_ALWAYS;
                w.target       = PC_FETCH;
            end
            4'd13: begin
                w.ctl.rd_store = 1'b1;
            end
            4'd14: begin
                w.ctl.emit = EM_READ;
                w.cond     = COND_ALWAYS;
                w.target   = PC_FETCH;
            end
            4'd15: begin
                w.ctl.emit = EM_PLAIN;
                w.cond     = COND_ALWAYS;
                w.target   = PC_FETCH;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage

// File: hdl/led_digit_chain_framer.sv
// top level of the led digit chain framer
// depends on ldcf_pkg, ldcf_seq, ldcf_dp and ldcf_ram
//
// Usage:
// - command channel: i_valid / o_stall; a command transfers at a clock edge with
//   i_valid high and o_stall low. o_stall is low only while the sequencer waits
//   at its fetch step, so one command is worked on at a time.
// - result channel: o_valid / i_stall; one result transfers per edge with o_valid
//   high and i_stall low. A command gives one result (set, read, any error,
//   empty chain, unused mode) or a run of serial words, farthest device
//   first, frame_end marking chip select release and last on the final word.
// - configuration: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index picks
//   chains in use, chain enable, devices on chain a, devices on chain b.
// - frames: register frames give one word per cycle while the result side does not stall,
//   then a closing step; row frames read the store and then emit each word, with a
//   row step and a jump step between rows and the row step alone after the last.
// - a stall on the result side holds the emitting step; the held result stays
//   in the output register while the sequencer waits.
// - reset clears the step counter, the output valid bit and the valid bits of the
//   digit store, so every digit reads zero, and loads the default configuration.
module led_digit_chain_framer
    import ldcf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_mode,
    input  logic [1:0] i_chain_sel,
    input  logic [3:0] i_device_sel,
    input  logic [3:0] i_digit_sel,
    input  logic [3:0] i_register_address,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_read_value,
    output logic       o_out_chain,
    output logic       o_word_valid,
    output logic [3:0] o_word_register,
    output logic [7:0] o_word_data,
    output logic       o_frame_end,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    t_ctl   ctl;
    t_flags flags;
    logic   go;

    // sequencer
    ldcf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_flags (flags),
        .o_ctl   (ctl),
        .o_go    (go)
    );

    // datapath
    ldcf_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .i_go               (go),
        .o_flags            (flags),
        .i_mode             (i_mode),
        .i_chain_sel        (i_chain_sel),
        .i_device_sel       (i_device_sel),
        .i_digit_sel        (i_digit_sel),
        .i_register_address (i_register_address),
        .i_data_byte        (i_data_byte),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_read_value       (o_read_value),
        .o_out_chain        (o_out_chain),
        .o_word_valid       (o_word_valid),
        .o_word_register    (o_word_register),
        .o_word_data        (o_word_data),
        .o_frame_end        (o_frame_end),
        .o_last             (o_last)
    );

    // commands transfer only at the fetch step
    assign o_stall     = !ctl.ld_cmd;
    assign o_cfg_ready = 1'b1;

endmodule

// File: hdl/ldcf_ram.sv
// generic single-port-write ram with registered read and read enable
// no dependencies
module ldcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, data holds while no read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/ldcf_seq.sv
// microcode sequencer: step counter, program table and conditional jumps
// depends on ldcf_pkg
module ldcf_seq
    import ldcf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_flags i_flags,
    output t_ctl   o_ctl,
    output logic   o_go
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w;
    logic            take;
    logic            go;

    assign w = ucode(r_pc);

    // a step holds while waiting for a command or for room in the output register
    always_comb begin
        go = (!w.ctl.ld_cmd || i_valid) && ((w.ctl.emit == EM_NONE) || i_flags.out_free);
        case (w.cond)
            COND_NEXT:      take = 1'b0;
            COND_ALWAYS:    take = 1'b1;
            COND_BAD:       take = i_flags.bad;
            COND_MODE_SET:  take = i_flags.mode_set;
            COND_MODE_READ: take = i_flags.mode_read;
            COND_NDEV_ZERO: take = i_flags.ndev_zero;
            COND_MODE_REG:  take = i_flags.mode_reg;
            COND_DEV_NZ:    take = !i_flags.dev_zero;
            COND_ROW_LAST:  take = i_flags.row_last;
            default:        take = 1'b0;
        endcase
        if (!go) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = w.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = w.ctl;
    assign o_go  = go;

endmodule

// File: hdl/ldcf_dp.sv
// datapath: command registers, checks, counters, digit store and output register
// depends on ldcf_pkg and ldcf_ram
module ldcf_dp
    import ldcf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctl       i_ctl,
    input  logic       i_go,
    output t_flags     o_flags,
    input  logic [2:0] i_mode,
    input  logic [1:0] i_chain_sel,
    input  logic [3:0] i_device_sel,
    input  logic [3:0] i_digit_sel,
    input  logic [3:0] i_register_address,
    input  logic [7:0] i_data_byte,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [7:0] o_read_value,
    output logic       o_out_chain,
    output logic       o_word_valid,
    output logic [3:0] o_word_register,
    output logic [7:0] o_word_data,
    output logic       o_frame_end,
    output logic       o_last
);

    // configuration registers
    logic [1:0] r_chains_in_use;
    logic [1:0] r_chain_enable;
    logic [3:0] r_devices_a;
    logic [3:0] r_devices_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chains_in_use <= CHAIN_MAX;
            r_chain_enable  <= 2'b11;
            r_devices_a     <= DEV_MAX;
            r_devices_b     <= DEV_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHAINS_IN_USE: r_chains_in_use <= i_cfg_data[1:0];
                CFG_CHAIN_ENABLE:  r_chain_enable  <= i_cfg_data[1:0];
                CFG_DEVICES_A:     r_devices_a     <= i_cfg_data;
                CFG_DEVICES_B:     r_devices_b     <= i_cfg_data;
                default:           r_chain_enable  <= r_chain_enable;
            endcase
        end
    end

    // checks on the incoming command
    logic       chain_ok;
    logic [3:0] dev_raw;
    logic [3:0] ndev;
    logic [1:0] status;
    logic       mode_ok;

    always_comb begin
        chain_ok = (i_chain_sel < CHAIN_MAX) && (i_chain_sel < r_chains_in_use) &&
                   r_chain_enable[i_chain_sel[0]];
        dev_raw  = i_chain_sel[0] ? r_devices_b : r_devices_a;
        ndev     = (dev_raw > DEV_MAX) ? DEV_MAX : dev_raw;
        mode_ok  = (i_mode <= MODE_ALL_ROWS);
        if (!mode_ok) begin
            status = ST_OK;
        end else if (!chain_ok) begin
            status = ST_BAD_CHAIN;
        end else if ((i_mode <= MODE_REG_ONE) && (i_device_sel >= ndev)) begin
            status = ST_BAD_DEVICE;
        end else if (((i_mode <= MODE_READ_DIGIT) || (i_mode == MODE_ONE_ROW)) &&
                     (i_digit_sel >= ROW_COUNT)) begin
            status = ST_BAD_DIGIT;
        end else begin
            status = ST_OK;
        end
    end

    // command registers and counters
    logic [2:0]       r_mode;
    logic             r_chain;
    logic [DEV_W-1:0] r_device;
    logic [ROW_W-1:0] r_digit;
    logic [3:0]       r_reg;
    logic [7:0]       r_data;
    logic [1:0]       r_status;
    logic             r_bad;
    logic             r_ndev_zero;
    logic [DEV_W-1:0] r_ndev_m1;
    logic [DEV_W-1:0] r_dev;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] r_last_row;
    logic             ld;

    assign ld = i_go && i_ctl.ld_cmd;

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_mode      <= i_mode;
            r_chain     <= i_chain_sel[0];
            r_device    <= i_device_sel[DEV_W-1:0];
            r_digit     <= i_digit_sel[ROW_W-1:0];
            r_reg       <= i_register_address;
            r_data      <= i_data_byte;
            r_status    <= status;
            r_bad       <= !mode_ok || (status != ST_OK);
            r_ndev_zero <= (ndev == 4'd0);
            r_ndev_m1   <= DEV_W'(ndev - 4'd1);
            r_dev       <= DEV_W'(ndev - 4'd1);
            r_row       <= (i_mode == MODE_ALL_ROWS) ? '0 : i_digit_sel[ROW_W-1:0];
            r_last_row  <= (i_mode == MODE_ALL_ROWS) ? ROW_W'(ROWS - 1) :
                                                       i_digit_sel[ROW_W-1:0];
        end else if (i_go) begin
            if (i_ctl.dev_init) begin
                r_dev <= r_ndev_m1;
            end else if (i_ctl.dev_dec) begin
                r_dev <= r_dev - 1'b1;
            end
            if (i_ctl.row_inc) begin
                r_row <= r_row + 1'b1;
            end
        end
    end

    // digit store with per-entry valid bits so unwritten entries read zero
    logic [ADDR_W-1:0]      addr;
    logic [STORE_DEPTH-1:0] r_vld;
    logic                   r_rd_hit;
    logic [7:0]             ram_q;
    logic [7:0]             store_q;
    logic                   we;
    logic                   re;

    assign addr = (i_ctl.addr_sel == ADDR_CNT) ? {r_chain, r_dev, r_row} :
                                                 {r_chain, r_device, r_digit};
    assign we   = i_go && i_ctl.wr_store;
    assign re   = i_go && i_ctl.rd_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (we) begin
            r_vld[addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_rd_hit <= r_vld[addr];
        end
    end

    ldcf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (r_data),
        .i_re    (re),
        .i_raddr (addr),
        .o_rdata (ram_q)
    );

    assign store_q = r_rd_hit ? ram_q : 8'h00;

    // result fields of the current step
    logic       dev_zero;
    logic       row_last;
    logic       hit;
    logic [1:0] n_status;
    logic [7:0] n_read_value;
    logic       n_out_chain;
    logic       n_word_valid;
    logic [3:0] n_word_register;
    logic [7:0] n_word_data;
    logic       n_frame_end;
    logic       n_last;

    assign dev_zero = (r_dev == '0);
    assign row_last = (r_row == r_last_row);
    assign hit      = (r_mode == MODE_REG_ALL) || (r_dev == r_device);

    always_comb begin
        n_status        = ST_OK;
        n_read_value    = 8'h00;
        n_out_chain     = 1'b0;
        n_word_valid    = 1'b0;
        n_word_register = 4'h0;
        n_word_data     = 8'h00;
        n_frame_end     = 1'b0;
        n_last          = 1'b1;
        case (i_ctl.emit)
            EM_PLAIN: begin
                n_status = r_status;
            end
            EM_READ: begin
                n_status     = r_status;
                n_read_value = store_q;
            end
            EM_REG: begin
                n_out_chain     = r_chain;
                n_word_valid    = 1'b1;
                n_word_register = hit ? r_reg : NOOP_REG;
                n_word_data     = hit ? r_data : 8'h00;
                n_frame_end     = dev_zero;
                n_last          = dev_zero;
            end
            EM_ROW: begin
                n_out_chain     = r_chain;
                n_word_valid    = 1'b1;
                n_word_register = 4'(r_row) + 4'd1;
                n_word_data     = store_q;
                n_frame_end     = dev_zero;
                n_last          = dev_zero && row_last;
            end
            default: begin
                n_last = 1'b1;
            end
        endcase
    end

    // output register
    logic r_out_valid;
    logic out_free;
    logic emit;

    assign out_free = !r_out_valid || !i_stall;
    assign emit     = i_go && (i_ctl.emit != EM_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_status        <= n_status;
            o_read_value    <= n_read_value;
            o_out_chain     <= n_out_chain;
            o_word_valid    <= n_word_valid;
            o_word_register <= n_word_register;
            o_word_data     <= n_word_data;
            o_frame_end     <= n_frame_end;
            o_last          <= n_last;
        end
    end

    assign o_valid = r_out_valid;

    // flags for the sequencer
    always_comb begin
        o_flags.bad       = r_bad;
        o_flags.mode_set  = (r_mode == MODE_SET_DIGIT);
        o_flags.mode_read = (r_mode == MODE_READ_DIGIT);
        o_flags.mode_reg  = (r_mode == MODE_REG_ONE) || (r_mode == MODE_REG_ALL);
        o_flags.ndev_zero = r_ndev_zero;
        o_flags.dev_zero  = dev_zero;
        o_flags.row_last  = row_last;
        o_flags.out_free  = out_free;
    end

endmodule

// File: test/tb_led_digit_chain_framer.sv
// self-checking testbench of the led digit chain framer: digit store, register and row frames
// depends on ldcf_pkg and led_digit_chain_framer; a scoreboard class predicts every result
`timescale 1ns / 1ps

module tb_led_digit_chain_framer;
    import ldcf_pkg::*;

    // one command as it goes into the block
    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] chain_sel;
        logic [3:0] device_sel;
        logic [3:0] digit_sel;
        logic [3:0] register_address;
        logic [7:0] data_byte;
    } t_display_cmd;

    // one result as it comes out of the block
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_value;
        logic       out_chain;
        logic       word_valid;
        logic [3:0] word_register;
        logic [7:0] word_data;
        logic       frame_end;
        logic       last;
    } t_frame_result;

    // predicts the frames and status of each command and checks the block's results
    class t_digit_frame_scoreboard;
        logic [7:0]    digit_copy [CHAINS*DEVICES_PER_CHAIN*ROWS];
        logic [1:0]    chains_in_use;
        logic [1:0]    chain_enable;
        logic [3:0]    dev_count [CHAINS];
        t_frame_result pending_results [$];
        int            mismatches;

        function new();
            foreach (digit_copy[i]) digit_copy[i] = '0;
            chains_in_use = CHAIN_MAX;
            chain_enable  = 2'b11;
            dev_count[0]  = DEV_MAX;
            dev_count[1]  = DEV_MAX;
            mismatches    = 0;
        endfunction

        function void write_register(logic [1:0] index, logic [3:0] value);
            case (index)
                CFG_CHAINS_IN_USE: chains_in_use = value[1:0];
                CFG_CHAIN_ENABLE:  chain_enable  = value[1:0];
                CFG_DEVICES_A:     dev_count[0]  = value;
                CFG_DEVICES_B:     dev_count[1]  = value;
                default: ;
            endcase
        endfunction

        // counts above the chain size behave as a full chain
        function int devices_used(int chain);
            int n;
            n = dev_count[chain];
            return (n > DEVICES_PER_CHAIN) ? DEVICES_PER_CHAIN : n;
        endfunction

        function int slot(int chain, int device, int row);
            return ((chain * DEVICES_PER_CHAIN) + device) * ROWS + row;
        endfunction

        function void push_plain(logic [1:0] status, logic [7:0] value);
            t_frame_result r;
            r = '0;
            r.status     = status;
            r.read_value = value;
            r.last       = 1'b1;
            pending_results.push_back(r);
        endfunction

        function void push_word(int chain, logic [3:0] addr, logic [7:0] data,
                                bit frame_end, bit last);
            t_frame_result r;
            r = '0;
            r.out_chain     = chain[0];
            r.word_valid    = 1'b1;
            r.word_register = addr;
            r.word_data     = data;
            r.frame_end     = frame_end;
            r.last          = last;
            pending_results.push_back(r);
        endfunction

        // expected results of one accepted command
        function void note_command(t_display_cmd c);
            int ch;
            int ndev;
            int first_row;
            int final_row;
            bit hit;
            ch = c.chain_sel;
            // unused modes are answered with a plain ok
            if (c.mode > MODE_ALL_ROWS) begin
                push_plain(ST_OK, 8'h00);
                return;
            end
            // chain, then device, then digit
            if (ch >= CHAINS || c.chain_sel >= chains_in_use || !chain_enable[ch[0]]) begin
                push_plain(ST_BAD_CHAIN, 8'h00);
                return;
            end
            ndev = devices_used(ch);
            if (c.mode <= MODE_REG_ONE && c.device_sel >= ndev) begin
                push_plain(ST_BAD_DEVICE, 8'h00);
                return;
            end
            if ((c.mode <= MODE_READ_DIGIT || c.mode == MODE_ONE_ROW) && c.digit_sel >= ROWS)
            begin
                push_plain(ST_BAD_DIGIT, 8'h00);
                return;
            end
            if (c.mode == MODE_SET_DIGIT) begin
                digit_copy[slot(ch, c.device_sel, c.digit_sel)] = c.data_byte;
                push_plain(ST_OK, 8'h00);
                return;
            end
            if (c.mode == MODE_READ_DIGIT) begin
                push_plain(ST_OK, digit_copy[slot(ch, c.device_sel, c.digit_sel)]);
                return;
            end
            // a frame on an empty chain sends nothing
            if (ndev == 0) begin
                push_plain(ST_OK, 8'h00);
                return;
            end
            // frames go farthest device first, chip select released after device zero
            if (c.mode == MODE_REG_ONE || c.mode == MODE_REG_ALL) begin
                for (int i = ndev - 1; i >= 0; i--) begin
                    hit = (c.mode == MODE_REG_ALL) || (i == c.device_sel);
                    push_word(ch, hit ? c.register_address : NOOP_REG,
                              hit ? c.data_byte : 8'h00, i == 0, i == 0);
                end
            end else begin
                first_row = (c.mode == MODE_ONE_ROW) ? c.digit_sel : 0;
                final_row = (c.mode == MODE_ONE_ROW) ? c.digit_sel : ROWS - 1;
                for (int row = first_row; row <= final_row; row++) begin
                    for (int i = ndev - 1; i >= 0; i--) begin
                        push_word(ch, 4'(row + 1), digit_copy[slot(ch, i, row)],
                                  i == 0, i == 0 && row == final_row);
                    end
                end
            end
        endfunction

        function void report(string what, t_frame_result want, t_frame_result got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] %s", $time, what);
                $display({"  expected status %0d read %02h chain %0d wv %0d",
                          " reg %0h data %02h fe %0d last %0d"},
                         want.status, want.read_value, want.out_chain, want.word_valid,
                         want.word_register, want.word_data, want.frame_end, want.last);
                $display({"  actual   status %0d read %02h chain %0d wv %0d",
                          " reg %0h data %02h fe %0d last %0d"},
                         got.status, got.read_value, got.out_chain, got.word_valid,
                         got.word_register, got.word_data, got.frame_end, got.last);
            end
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(t_frame_result got);
            t_frame_result want;
            if (pending_results.size() == 0) begin
                report("result with nothing expected", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.out_chain !== want.out_chain || got.word_valid !== want.word_valid ||
                got.word_register !== want.word_register || got.word_data !== want.word_data ||
                got.frame_end !== want.frame_end || got.last !== want.last) begin
                report("result mismatch", want, got);
            end
        endfunction
    endclass

    logic       i_clk              = 1'b0;
    logic       i_rst_n            = 1'b0;
    logic       i_valid            = 1'b0;
    logic       o_stall;
    logic [2:0] i_mode             = '0;
    logic [1:0] i_chain_sel        = '0;
    logic [3:0] i_device_sel       = '0;
    logic [3:0] i_digit_sel        = '0;
    logic [3:0] i_register_address = '0;
    logic [7:0] i_data_byte        = '0;
    logic       o_valid;
    logic       i_stall            = 1'b0;
    logic [1:0] o_status;
    logic [7:0] o_read_value;
    logic       o_out_chain;
    logic       o_word_valid;
    logic [3:0] o_word_register;
    logic [7:0] o_word_data;
    logic       o_frame_end;
    logic       o_last;
    logic       i_cfg_valid        = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index        = '0;
    logic [3:0] i_cfg_data         = '0;

    t_digit_frame_scoreboard frames = new();
    bit steady_run = 1'b0;

    led_digit_chain_framer uut (.*);

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver stalls at random unless in a steady stretch
    always @(negedge i_clk) begin
        i_stall = !steady_run && ($urandom_range(99) < 29);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            frames.check_result(t_frame_result'({o_status, o_read_value, o_out_chain,
                o_word_valid, o_word_register, o_word_data, o_frame_end, o_last}));
        end
    end

    // one command transfer, at random with a gap before it unless in a steady stretch
    task automatic send_command(t_display_cmd c);
        @(negedge i_clk);
        if (!steady_run && $urandom_range(99) < 29) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_mode             = c.mode;
        i_chain_sel        = c.chain_sel;
        i_device_sel       = c.device_sel;
        i_digit_sel        = c.digit_sel;
        i_register_address = c.register_address;
        i_data_byte        = c.data_byte;
        i_valid            = 1'b1;
        do @(posedge i_clk); while (o_stall);
        frames.note_command(c);
    endtask

    task automatic send_fields(logic [2:0] mode, logic [1:0] chain, logic [3:0] device,
                               logic [3:0] digit, logic [3:0] addr, logic [7:0] data);
        send_command({mode, chain, device, digit, addr, data});
    endtask

    // mostly well-formed commands for the current setting, some noise
    task automatic send_random_command();
        t_display_cmd c;
        int pick;
        int ndev;
        pick             = $urandom_range(99);
        c.chain_sel      = 2'($urandom_range(1));
        ndev             = frames.devices_used(c.chain_sel);
        c.device_sel     = (ndev == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(ndev - 1));
        c.digit_sel      = 4'($urandom_range(ROWS - 1));
        c.register_address = 4'($urandom_range(15));
        c.data_byte      = 8'($urandom_range(255));
        if (pick < 12)      c = t_display_cmd'(25'($urandom));
        else if (pick < 45) c.mode = MODE_SET_DIGIT;
        else if (pick < 62) c.mode = MODE_READ_DIGIT;
        else if (pick < 70) c.mode = MODE_REG_ONE;
        else if (pick < 78) c.mode = MODE_REG_ALL;
        else if (pick < 90) c.mode = MODE_ONE_ROW;
        else                c.mode = MODE_ALL_ROWS;
        send_command(c);
    endtask

    task automatic write_register(logic [1:0] index, logic [3:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        frames.write_register(index, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // hold the sender until every expected result is back, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (frames.pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [3:0] chains, logic [3:0] enables, logic [3:0] dev_a,
                             logic [3:0] dev_b, int items, bit calm);
        wait_idle();
        write_register(CFG_CHAINS_IN_USE, chains);
        write_register(CFG_CHAIN_ENABLE, enables);
        write_register(CFG_DEVICES_A, dev_a);
        write_register(CFG_DEVICES_B, dev_b);
        steady_run = calm;
        repeat (items) send_random_command();
        steady_run = 1'b0;
    endtask

    // stimulus
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed commands at the reset setting
        send_fields(MODE_SET_DIGIT,  2'd0, 4'd0, 4'd0, 4'h0, 8'hFF);
        send_fields(MODE_SET_DIGIT,  2'd1, 4'd7, 4'd7, 4'hF, 8'h80);
        send_fields(MODE_SET_DIGIT,  2'd0, 4'd7, 4'd3, 4'h5, 8'h5A);
        send_fields(MODE_SET_DIGIT,  2'd0, 4'd4, 4'd0, 4'h0, 8'h00);
        send_fields(MODE_READ_DIGIT, 2'd1, 4'd7, 4'd7, 4'h0, 8'h00);
        send_fields(MODE_READ_DIGIT, 2'd0, 4'd3, 4'd5, 4'hF, 8'hFF);
        send_fields(MODE_READ_DIGIT, 2'd0, 4'd0, 4'd0, 4'h0, 8'h00);
        send_fields(MODE_REG_ONE,    2'd0, 4'd7, 4'd0, 4'hF, 8'hA5);
        send_fields(MODE_REG_ONE,    2'd1, 4'd0, 4'd0, 4'hC, 8'h01);
        send_fields(MODE_REG_ALL,    2'd1, 4'd15, 4'd15, 4'h9, 8'hFF);
        send_fields(MODE_ONE_ROW,    2'd0, 4'd12, 4'd0, 4'h0, 8'h00);
        send_fields(MODE_ONE_ROW,    2'd1, 4'd0, 4'd7, 4'h3, 8'h11);
        send_fields(MODE_ALL_ROWS,   2'd0, 4'd15, 4'd15, 4'hF, 8'hFF);
        // unused modes are ignored even with bad fields
        send_fields(3'd6,            2'd0, 4'd0, 4'd0, 4'h0, 8'h00);
        send_fields(3'd7,            2'd3, 4'd15, 4'd15, 4'hF, 8'hFF);
        // chain out of range
        send_fields(MODE_SET_DIGIT,  2'd2, 4'd0, 4'd0, 4'h0, 8'h12);
        send_fields(MODE_ALL_ROWS,   2'd3, 4'd15, 4'd15, 4'h0, 8'h00);
        // device out of range, with the chain checked before it
        send_fields(MODE_SET_DIGIT,  2'd0, 4'd8, 4'd0, 4'h0, 8'h34);
        send_fields(MODE_REG_ONE,    2'd1, 4'd15, 4'd0, 4'h1, 8'h01);
        send_fields(MODE_READ_DIGIT, 2'd3, 4'd15, 4'd15, 4'h0, 8'h00);
        // digit out of range, with the device checked before it
        send_fields(MODE_READ_DIGIT, 2'd0, 4'd2, 4'd8, 4'h0, 8'h00);
        send_fields(MODE_ONE_ROW,    2'd1, 4'd0, 4'd15, 4'h0, 8'h00);
        send_fields(MODE_SET_DIGIT,  2'd1, 4'd9, 4'd9, 4'h0, 8'h56);
        send_fields(MODE_READ_DIGIT, 2'd0, 4'd7, 4'd3, 4'h0, 8'h00);

        // random phases across settings: full, partial, empty, disabled, oversized
        run_phase(4'd2, 4'd3, 4'd8, 4'd8, 50, 1'b1);
        run_phase(4'd1, 4'd3, 4'd3, 4'd15, 45, 1'b0);
        run_phase(4'd3, 4'd2, 4'd0, 4'd5, 45, 1'b0);
        run_phase(4'd0, 4'd1, 4'd8, 4'd1, 20, 1'b0);
        run_phase(4'hE, 4'hD, 4'd1, 4'd8, 45, 1'b0);
        run_phase(4'($urandom_range(15)), 4'($urandom_range(15)),
                  4'($urandom_range(15)), 4'($urandom_range(15)), 45, 1'b0);
        run_phase(4'd2, 4'd3, 4'd8, 4'd8, 60, 1'b0);
        wait_idle();

        if (frames.mismatches == 0 && frames.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
